>>> rtl/tcw_pkg.sv
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int NCELLS  = ROWS * COLUMNS;

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ADDR_W = $clog2(NCELLS);

  // Fixed port widths
  localparam int IN_ROW_W = 5;
  localparam int IN_COL_W = 7;
  localparam int POS_W    = 11;
  localparam int CLR_W    = 4;

  // Command queue depth between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [ROW_W:0]    row_ext_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [COL_W:0]    col_ext_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [15:0]       cell_t;

  // Character codes and cell constants
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h0F;

  // Spaces written per tab, minus the first
  localparam logic [1:0] TAB_EXTRA = 2'd3;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_SET   = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  // Configuration register indexes
  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  // Classified operation kinds
  typedef enum logic [3:0] {
    K_PLAIN,
    K_NL,
    K_CR,
    K_TAB,
    K_BS,
    K_CLEAR,
    K_SET,
    K_READ,
    K_NOP
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] ch;
    row_t       row;
    col_t       col;
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RUN,
    ST_SCROLL,
    ST_CLEAR,
    ST_DONE
  } back_state_t;

endpackage

>>> rtl/tcw_front.sv
module tcw_front (
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_action,
  input  logic [7:0]                        in_char_code,
  input  logic [tcw_pkg::IN_ROW_W-1:0]      in_target_row,
  input  logic [tcw_pkg::IN_COL_W-1:0]      in_target_col,
  input  logic                              q_full,
  input  logic                              init_active,
  output logic                              push,
  output tcw_pkg::op_t                      push_op
);

  logic in_range;

  // Stall while the queue is full or the screen store is being initialized
  assign busy = q_full | init_active;
  assign push = start & ~busy;

  assign in_range = (32'(in_target_row) < tcw_pkg::ROWS) &&
                    (32'(in_target_col) < tcw_pkg::COLUMNS);

  // Classify the request
  always_comb begin
    push_op.ch   = in_char_code;
    push_op.row  = tcw_pkg::row_t'(in_target_row);
    push_op.col  = tcw_pkg::col_t'(in_target_col);
    push_op.kind = tcw_pkg::K_NOP;
    unique case (tcw_pkg::action_t'(in_action))
      tcw_pkg::ACT_PUT: begin
        unique case (in_char_code)
          tcw_pkg::CH_NL:  push_op.kind = tcw_pkg::K_NL;
          tcw_pkg::CH_CR:  push_op.kind = tcw_pkg::K_CR;
          tcw_pkg::CH_TAB: push_op.kind = tcw_pkg::K_TAB;
          tcw_pkg::CH_BS:  push_op.kind = tcw_pkg::K_BS;
          default:         push_op.kind = tcw_pkg::K_PLAIN;
        endcase
      end
      tcw_pkg::ACT_CLEAR: push_op.kind = tcw_pkg::K_CLEAR;
      tcw_pkg::ACT_SET:   push_op.kind = in_range ? tcw_pkg::K_SET : tcw_pkg::K_NOP;
      tcw_pkg::ACT_READ:  push_op.kind = in_range ? tcw_pkg::K_READ : tcw_pkg::K_NOP;
      default:            push_op.kind = tcw_pkg::K_NOP;
    endcase
  end

endmodule

>>> rtl/tcw_queue.sv
module tcw_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  tcw_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output tcw_pkg::op_t pop_op,
  output logic         empty
);

  tcw_pkg::op_t                entry_r [tcw_pkg::QUEUE_DEPTH];
  logic [tcw_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [tcw_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [tcw_pkg::QPTR_W:0]    count_r, count_nxt;

  assign full   = (32'(count_r) == tcw_pkg::QUEUE_DEPTH);
  assign empty  = (count_r == '0);
  assign pop_op = entry_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == tcw_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == tcw_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

>>> rtl/tcw_back.sv
module tcw_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [7:0]                   attr,
  input  logic                         q_empty,
  input  tcw_pkg::op_t                 q_op,
  output logic                         q_pop,
  output logic                         init_active,
  output logic                         out_valid,
  output logic [4:0]                   out_cursor_row,
  output logic [6:0]                   out_cursor_col,
  output logic [tcw_pkg::POS_W-1:0]    out_cursor_pos,
  output logic [7:0]                   out_cell_char,
  output logic [7:0]                   out_cell_attribute
);

  tcw_pkg::back_state_t state_r, state_nxt;
  tcw_pkg::op_t         op_r, op_nxt;
  tcw_pkg::row_t        cur_row_r, cur_row_nxt;
  tcw_pkg::col_t        cur_col_r, cur_col_nxt;
  tcw_pkg::row_t        top_r, top_nxt;
  logic [1:0]           rep_r, rep_nxt;
  tcw_pkg::addr_t       sweep_r, sweep_nxt;
  logic                 cell_sel_r, cell_sel_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [4:0]           out_row_r, out_row_nxt;
  logic [6:0]           out_col_r, out_col_nxt;
  tcw_pkg::pos_t        out_pos_r, out_pos_nxt;
  logic [7:0]           out_char_r, out_char_nxt;
  logic [7:0]           out_attr_r, out_attr_nxt;

  // Screen store: rows are kept as a ring, top_r is the physical top row
  tcw_pkg::cell_t       mem [tcw_pkg::NCELLS];
  tcw_pkg::cell_t       rdata_r;
  logic                 mem_we;
  logic                 mem_re;
  tcw_pkg::addr_t       mem_addr;
  tcw_pkg::cell_t       mem_wdata;

  tcw_pkg::row_t        sel_row;
  tcw_pkg::col_t        sel_col;
  tcw_pkg::row_ext_t    row_sum;
  tcw_pkg::row_t        phys_row;
  tcw_pkg::addr_t       cell_addr;
  tcw_pkg::col_ext_t    col_inc;
  tcw_pkg::row_ext_t    row_inc;
  tcw_pkg::addr_t       pos_full;
  logic                 wrap;

  assign init_active = (state_r == tcw_pkg::ST_INIT);

  // Logical to physical cell address
  always_comb begin
    if (state_r == tcw_pkg::ST_SCROLL) begin
      sel_row = tcw_pkg::row_t'(tcw_pkg::ROWS - 1);
      sel_col = tcw_pkg::col_t'(sweep_r);
    end else if (op_r.kind == tcw_pkg::K_READ) begin
      sel_row = op_r.row;
      sel_col = op_r.col;
    end else begin
      sel_row = cur_row_r;
      sel_col = cur_col_r;
    end
    row_sum  = {1'b0, sel_row} + {1'b0, top_r};
    phys_row = (row_sum >= tcw_pkg::row_ext_t'(tcw_pkg::ROWS)) ?
               tcw_pkg::row_t'(row_sum - tcw_pkg::row_ext_t'(tcw_pkg::ROWS)) :
               tcw_pkg::row_t'(row_sum);
    cell_addr = tcw_pkg::addr_t'(phys_row) * tcw_pkg::addr_t'(tcw_pkg::COLUMNS) +
                tcw_pkg::addr_t'(sel_col);
  end

  // Cursor advance terms
  assign col_inc  = {1'b0, cur_col_r} + 1'b1;
  assign row_inc  = {1'b0, cur_row_r} + 1'b1;
  assign wrap     = (op_r.kind == tcw_pkg::K_NL) ||
                    (col_inc >= tcw_pkg::col_ext_t'(tcw_pkg::COLUMNS));
  assign pos_full = tcw_pkg::addr_t'(cur_row_r) * tcw_pkg::addr_t'(tcw_pkg::COLUMNS) +
                    tcw_pkg::addr_t'(cur_col_r);

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    top_nxt       = top_r;
    rep_nxt       = rep_r;
    sweep_nxt     = sweep_r;
    cell_sel_nxt  = cell_sel_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = cell_addr;
    mem_wdata     = {attr, tcw_pkg::CH_SPACE};
    out_valid_nxt = 1'b0;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_pos_nxt   = out_pos_r;
    out_char_nxt  = out_char_r;
    out_attr_nxt  = out_attr_r;

    unique case (state_r)
      // Power-up blanking of the whole store
      tcw_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_addr  = sweep_r;
        mem_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::CH_SPACE};
        if (32'(sweep_r) == tcw_pkg::NCELLS - 1) begin
          sweep_nxt = '0;
          state_nxt = tcw_pkg::ST_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end

      // Take the next request from the queue
      tcw_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop        = 1'b1;
          op_nxt       = q_op;
          rep_nxt      = (q_op.kind == tcw_pkg::K_TAB) ? tcw_pkg::TAB_EXTRA : 2'd0;
          cell_sel_nxt = 1'b0;
          state_nxt    = tcw_pkg::ST_RUN;
        end
      end

      tcw_pkg::ST_RUN: begin
        state_nxt = tcw_pkg::ST_DONE;
        case (op_r.kind) inside
          tcw_pkg::K_PLAIN, tcw_pkg::K_TAB, tcw_pkg::K_NL: begin
            if (op_r.kind != tcw_pkg::K_NL) begin
              mem_we    = 1'b1;
              mem_wdata = {attr, (op_r.kind == tcw_pkg::K_TAB) ? tcw_pkg::CH_SPACE : op_r.ch};
            end
            if (wrap) begin
              cur_col_nxt = '0;
              if (row_inc >= tcw_pkg::row_ext_t'(tcw_pkg::ROWS)) begin
                // Past the bottom: rotate the ring and blank the new bottom row
                cur_row_nxt = tcw_pkg::row_t'(tcw_pkg::ROWS - 1);
                top_nxt     = (32'(top_r) == tcw_pkg::ROWS - 1) ? '0 : top_r + 1'b1;
                sweep_nxt   = '0;
                state_nxt   = tcw_pkg::ST_SCROLL;
              end else begin
                cur_row_nxt = tcw_pkg::row_t'(row_inc);
              end
            end else begin
              cur_col_nxt = tcw_pkg::col_t'(col_inc);
            end
            if (state_nxt != tcw_pkg::ST_SCROLL && rep_r != 2'd0) begin
              rep_nxt   = rep_r - 1'b1;
              state_nxt = tcw_pkg::ST_RUN;
            end
          end
          tcw_pkg::K_CR: cur_col_nxt = '0;
          tcw_pkg::K_BS: begin
            if (cur_col_r != '0) begin
              cur_col_nxt = cur_col_r - 1'b1;
            end
          end
          tcw_pkg::K_SET: begin
            cur_row_nxt = op_r.row;
            cur_col_nxt = op_r.col;
          end
          tcw_pkg::K_CLEAR: begin
            sweep_nxt = '0;
            state_nxt = tcw_pkg::ST_CLEAR;
          end
          tcw_pkg::K_READ: begin
            mem_re       = 1'b1;
            cell_sel_nxt = 1'b1;
          end
          default: ;
        endcase
      end

      // Blank the bottom row after a scroll
      tcw_pkg::ST_SCROLL: begin
        mem_we = 1'b1;
        if (32'(sweep_r) == tcw_pkg::COLUMNS - 1) begin
          sweep_nxt = '0;
          if (rep_r != 2'd0) begin
            rep_nxt   = rep_r - 1'b1;
            state_nxt = tcw_pkg::ST_RUN;
          end else begin
            state_nxt = tcw_pkg::ST_DONE;
          end
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end

      // Clear screen: blank every cell, reset the ring and cursor
      tcw_pkg::ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = sweep_r;
        if (32'(sweep_r) == tcw_pkg::NCELLS - 1) begin
          sweep_nxt   = '0;
          top_nxt     = '0;
          cur_row_nxt = '0;
          cur_col_nxt = '0;
          state_nxt   = tcw_pkg::ST_DONE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end

      // Present the result
      tcw_pkg::ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_row_nxt   = 5'(cur_row_r);
        out_col_nxt   = 7'(cur_col_r);
        out_pos_nxt   = tcw_pkg::pos_t'(pos_full);
        out_char_nxt  = cell_sel_r ? rdata_r[7:0]  : 8'h00;
        out_attr_nxt  = cell_sel_r ? rdata_r[15:8] : 8'h00;
        state_nxt     = tcw_pkg::ST_IDLE;
      end

      default: state_nxt = tcw_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_INIT;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      top_r       <= '0;
      rep_r       <= '0;
      sweep_r     <= '0;
      cell_sel_r  <= 1'b0;
      out_valid_r <= 1'b0;
      op_r.kind   <= tcw_pkg::K_NOP;
      op_r.ch     <= '0;
      op_r.row    <= '0;
      op_r.col    <= '0;
    end else begin
      state_r     <= state_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      top_r       <= top_nxt;
      rep_r       <= rep_nxt;
      sweep_r     <= sweep_nxt;
      cell_sel_r  <= cell_sel_nxt;
      out_valid_r <= out_valid_nxt;
      op_r        <= op_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_pos_r  <= out_pos_nxt;
    out_char_r <= out_char_nxt;
    out_attr_r <= out_attr_nxt;
  end

  // Screen store port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cursor_row     = out_row_r;
  assign out_cursor_col     = out_col_r;
  assign out_cursor_pos     = out_pos_r;
  assign out_cell_char      = out_char_r;
  assign out_cell_attribute = out_attr_r;

endmodule

>>> rtl/text_console_char_writer.sv
// Sequence: a request taken from the queue is executed in RUN and its result registered in DONE;
// a tab repeats RUN for three more spaces; a scroll blanks the bottom row's COLUMNS (80) cells
// in SCROLL; clear screen blanks all NCELLS (2000) cells, one cell per cycle on the store port.
// Intake: a 2-entry queue lets new requests be taken while the sequencer works on earlier ones.
// Reset: a pass blanks every screen store cell (busy high); config writes are taken meanwhile.
// The result strobe lasts one cycle and the receiver cannot stall it.
module text_console_char_writer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_action,
  input  logic [7:0]                     in_char_code,
  input  logic [tcw_pkg::IN_ROW_W-1:0]   in_target_row,
  input  logic [tcw_pkg::IN_COL_W-1:0]   in_target_col,
  output logic                           out_valid,
  output logic [4:0]                     out_cursor_row,
  output logic [6:0]                     out_cursor_col,
  output logic [tcw_pkg::POS_W-1:0]      out_cursor_pos,
  output logic [7:0]                     out_cell_char,
  output logic [7:0]                     out_cell_attribute,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [tcw_pkg::CLR_W-1:0]      cfg_wdata
);

  logic [tcw_pkg::CLR_W-1:0] fg_r;
  logic [tcw_pkg::CLR_W-1:0] bg_r;
  logic                      q_full;
  logic                      q_empty;
  logic                      q_push;
  logic                      q_pop;
  logic                      init_active;
  tcw_pkg::op_t              push_op;
  tcw_pkg::op_t              pop_op;

  // Color registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= 4'hF;
      bg_r <= 4'h0;
    end else if (cfg_we) begin
      if (cfg_index == tcw_pkg::REG_FG) begin
        fg_r <= cfg_wdata;
      end
      if (cfg_index == tcw_pkg::REG_BG) begin
        bg_r <= cfg_wdata;
      end
    end
  end

  tcw_front u_front (
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_char_code  (in_char_code),
    .in_target_row (in_target_row),
    .in_target_col (in_target_col),
    .q_full        (q_full),
    .init_active   (init_active),
    .push          (q_push),
    .push_op       (push_op)
  );

  tcw_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .pop_op  (pop_op),
    .empty   (q_empty)
  );

  tcw_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .attr               ({bg_r, fg_r}),
    .q_empty            (q_empty),
    .q_op               (pop_op),
    .q_pop              (q_pop),
    .init_active        (init_active),
    .out_valid          (out_valid),
    .out_cursor_row     (out_cursor_row),
    .out_cursor_col     (out_cursor_col),
    .out_cursor_pos     (out_cursor_pos),
    .out_cell_char      (out_cell_char),
    .out_cell_attribute (out_cell_attribute)
  );

endmodule

>>> sim/tb_text_console_char_writer.sv
`timescale 1ns / 1ps

module tb_text_console_char_writer;
  import tcw_pkg::*;

  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int ITEMS_PER_PHASE = 245;

  // One cursor report as the block returns it
  typedef struct {
    logic [4:0] row;
    logic [6:0] col;
    pos_t       pos;
    logic [7:0] ch;
    logic [7:0] attr;
  } cursor_report_t;

  // Console model plus the store of cursor reports still to arrive
  class console_scoreboard;
    cell_t          screen [NCELLS];
    logic [4:0]     cur_row;
    logic [6:0]     cur_col;
    logic [3:0]     fg;
    logic [3:0]     bg;
    cursor_report_t expected_q[$];
    int unsigned    mismatches;

    function new();
      foreach (screen[i]) screen[i] = {RESET_ATTR, CH_SPACE};
      cur_row    = '0;
      cur_col    = '0;
      fg         = 4'hF;
      bg         = 4'h0;
      mismatches = 0;
    endfunction

    function void set_colors(logic [3:0] f, logic [3:0] b);
      fg = f;
      bg = b;
    endfunction

    function logic [7:0] cell_attr();
      return {bg, fg};
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void blank_cells(int from, int upto);
      for (int i = from; i < upto; i++) screen[i] = {cell_attr(), CH_SPACE};
    endfunction

    // Column 0 of the next row; at the bottom the screen scrolls up a line
    function void next_line();
      cur_col = '0;
      if (cur_row == ROWS - 1) begin
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
        blank_cells((ROWS - 1) * COLUMNS, NCELLS);
      end else begin
        cur_row++;
      end
    endfunction

    function void put_plain(logic [7:0] ch);
      screen[int'(cur_row) * COLUMNS + int'(cur_col)] = {cell_attr(), ch};
      if (cur_col == COLUMNS - 1) next_line();
      else cur_col++;
    endfunction

    function void put_code(logic [7:0] ch);
      case (ch)
        CH_NL:  next_line();
        CH_CR:  cur_col = '0;
        CH_TAB: for (int i = 0; i < 4; i++) put_plain(CH_SPACE);
        CH_BS:  if (cur_col != 0) cur_col--;
        default: put_plain(ch);
      endcase
    endfunction

    // Apply an accepted request and queue the cursor report it must give
    function void note_request(action_t act, logic [7:0] ch, logic [4:0] trow,
                               logic [6:0] tcol);
      cursor_report_t rep;
      bit             in_range;
      in_range = (trow < ROWS) && (tcol < COLUMNS);
      rep.ch   = '0;
      rep.attr = '0;
      case (act)
        ACT_PUT: put_code(ch);
        ACT_CLEAR: begin
          blank_cells(0, NCELLS);
          cur_row = '0;
          cur_col = '0;
        end
        ACT_SET: begin
          if (in_range) begin
            cur_row = trow;
            cur_col = tcol;
          end
        end
        default: begin
          if (in_range) {rep.attr, rep.ch} = screen[int'(trow) * COLUMNS + int'(tcol)];
        end
      endcase
      rep.row = cur_row;
      rep.col = cur_col;
      rep.pos = POS_W'(int'(cur_row) * COLUMNS + int'(cur_col));
      expected_q.push_back(rep);
    endfunction

    function void check_result(logic [4:0] r, logic [6:0] c, pos_t p, logic [7:0] ch,
                               logic [7:0] at);
      cursor_report_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: cursor report with no request outstanding: row %0d col %0d",
                   $time, r, c);
        return;
      end
      want = expected_q.pop_front();
      if (r !== want.row || c !== want.col || p !== want.pos || ch !== want.ch ||
          at !== want.attr) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: exp r%0d c%0d p%0d ch%02h at%02h got r%0d c%0d p%0d ch%02h at%02h",
                   $time, want.row, want.col, want.pos, want.ch, want.attr,
                   r, c, p, ch, at);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          in_action = '0;
  logic [7:0]          in_char_code = '0;
  logic [IN_ROW_W-1:0] in_target_row = '0;
  logic [IN_COL_W-1:0] in_target_col = '0;
  logic                out_valid;
  logic [4:0]          out_cursor_row;
  logic [6:0]          out_cursor_col;
  pos_t                out_cursor_pos;
  logic [7:0]          out_cell_char;
  logic [7:0]          out_cell_attribute;
  logic                cfg_we = 1'b0;
  logic                cfg_index = 1'b0;
  logic [CLR_W-1:0]    cfg_wdata = '0;

  console_scoreboard sb;
  int                cycle_count = 0;

  text_console_char_writer u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_char_code       (in_char_code),
    .in_target_row      (in_target_row),
    .in_target_col      (in_target_col),
    .out_valid          (out_valid),
    .out_cursor_row     (out_cursor_row),
    .out_cursor_col     (out_cursor_col),
    .out_cursor_pos     (out_cursor_pos),
    .out_cell_char      (out_cell_char),
    .out_cell_attribute (out_cell_attribute),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_cursor_row, out_cursor_col, out_cursor_pos, out_cell_char,
                      out_cell_attribute);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Hold a request until the block takes it; start stays high for the caller
  task automatic issue_request(input action_t act, input logic [7:0] ch,
                               input logic [4:0] trow, input logic [6:0] tcol);
    start         <= 1'b1;
    in_action     <= act;
    in_char_code  <= ch;
    in_target_row <= trow;
    in_target_col <= tcol;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(act, ch, trow, tcol);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_colors(input logic [3:0] f, input logic [3:0] b);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FG;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_index <= REG_BG;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_colors(f, b);
  endtask

  // Mostly in range, often near the bottom right corner to force wraps and scrolls
  function automatic void aim_target(inout logic [4:0] trow, inout logic [6:0] tcol);
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        trow = 5'($urandom_range(ROWS - 5, ROWS - 1));
        tcol = 7'($urandom_range(COLUMNS - 20, COLUMNS - 1));
      end
      default: begin
        trow = 5'($urandom_range(0, ROWS - 1));
        tcol = 7'($urandom_range(0, COLUMNS - 1));
      end
    endcase
  endfunction

  task automatic random_request(output action_t act, output logic [7:0] ch,
                                output logic [4:0] trow, output logic [6:0] tcol);
    int pick;
    pick = $urandom_range(0, 99);
    ch   = 8'($urandom_range(0, 255));
    trow = 5'($urandom_range(0, 31));
    tcol = 7'($urandom_range(0, 127));
    if (pick < 55) begin
      act = ACT_PUT;
      case ($urandom_range(0, 9))
        0, 1: begin
          case ($urandom_range(0, 3))
            0: ch = CH_NL;
            1: ch = CH_CR;
            2: ch = CH_TAB;
            default: ch = CH_BS;
          endcase
        end
        2, 3, 4: ;
        default: ch = 8'($urandom_range(8'h20, 8'h7E));
      endcase
    end else if (pick < 57) begin
      act = ACT_CLEAR;
    end else if (pick < 75) begin
      act = ACT_SET;
      aim_target(trow, tcol);
    end else begin
      act = ACT_READ;
      aim_target(trow, tcol);
    end
  endtask

  task automatic run_random(input int count, input bit allow_idle);
    action_t    act;
    logic [7:0] ch;
    logic [4:0] trow;
    logic [6:0] tcol;
    for (int n = 0; n < count; n++) begin
      // idle in alternating stretches of 40 requests
      if (allow_idle && ((n / 40) % 2 == 0) && $urandom_range(0, 2) == 0) idle_burst();
      random_request(act, ch, trow, tcol);
      issue_request(act, ch, trow, tcol);
    end
  endtask

  // Reset contents, range edges and every control code under reset colors
  task automatic run_directed();
    issue_request(ACT_READ, 8'h00, 5'd0, 7'd0);
    issue_request(ACT_READ, 8'hFF, 5'd24, 7'd79);
    issue_request(ACT_READ, 8'h00, 5'd25, 7'd0);
    issue_request(ACT_READ, 8'h00, 5'd0, 7'd80);
    issue_request(ACT_READ, 8'h00, 5'd31, 7'd127);
    issue_request(ACT_PUT, 8'h41, 5'd0, 7'd0);
    issue_request(ACT_PUT, 8'h00, 5'd31, 7'd127);
    issue_request(ACT_PUT, 8'hFF, 5'd0, 7'd0);
    issue_request(ACT_PUT, CH_TAB, 5'd0, 7'd0);
    issue_request(ACT_PUT, CH_BS, 5'd0, 7'd0);
    issue_request(ACT_PUT, CH_CR, 5'd0, 7'd0);
    issue_request(ACT_PUT, CH_BS, 5'd0, 7'd0);
    issue_request(ACT_PUT, CH_NL, 5'd0, 7'd0);
    issue_request(ACT_READ, 8'h00, 5'd0, 7'd2);
    issue_request(ACT_SET, 8'h00, 5'd31, 7'd127);
    issue_request(ACT_SET, 8'h00, 5'd24, 7'd80);
    issue_request(ACT_SET, 8'h00, 5'd24, 7'd78);
    issue_request(ACT_PUT, CH_TAB, 5'd0, 7'd0);
    issue_request(ACT_READ, 8'h00, 5'd23, 7'd79);
    issue_request(ACT_PUT, CH_NL, 5'd0, 7'd0);
    issue_request(ACT_SET, 8'h00, 5'd24, 7'd79);
    issue_request(ACT_PUT, 8'h7E, 5'd0, 7'd0);
    issue_request(ACT_READ, 8'h00, 5'd22, 7'd79);
    issue_request(ACT_CLEAR, 8'hFF, 5'd31, 7'd127);
    issue_request(ACT_READ, 8'h00, 5'd12, 7'd40);
  endtask

  initial begin
    logic [3:0] f;
    logic [3:0] b;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // power-up blanking pass
    while (busy) @(posedge clk);
    run_directed();

    // color phases; the last one runs without idling
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          f = 4'h0;
          b = 4'hF;
        end
        1: begin
          f = 4'hF;
          b = 4'h0;
        end
        2: begin
          f = 4'h0;
          b = 4'h0;
        end
        default: begin
          f = 4'($urandom_range(0, 15));
          b = 4'($urandom_range(0, 15));
        end
      endcase
      write_colors(f, b);
      run_random(ITEMS_PER_PHASE, ph != 3);
    end

    drain();
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> text_console_char_writer.f
rtl/tcw_pkg.sv
rtl/tcw_front.sv
rtl/tcw_queue.sv
rtl/tcw_back.sv
rtl/text_console_char_writer.sv
sim/tb_text_console_char_writer.sv
